@@ hw/rtl/assert_macros.svh @@
// assertion helper macros for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// property also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed: label");

`endif

@@ hw/rtl/drp_pkg.sv @@
// -----------------------------------------------------------------------------
// drp_pkg
// Shared types, constants and the arctangent table of the position integrator.
// -----------------------------------------------------------------------------
`default_nettype none
package drp_pkg;

   localparam int SPEED_W = 16;
   localparam int TIME_W  = 32;
   localparam int HEAD_W  = 16;
   localparam int POS_W   = 64;
   localparam int TRIG_W  = 16;
   localparam int CRD_W   = 34;   // q30 cordic values with headroom
   localparam int ANG_W   = 33;   // residual angle, 32 bit turn units plus sign
   localparam int TAB_LEN = 24;
   localparam int STEP_W  = 5;
   localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;
   localparam int DIST_W  = 49;   // speed * signed dt
   localparam int PROD_W  = 65;   // dist * trig, exact for the whole range

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MULX,
      ST_MULY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } cordic_ctl_type;

   function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051D;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2E;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/drp_if.sv @@
// -----------------------------------------------------------------------------
// drp_req_if / drp_rsp_if
// Valid/ready channels for movement commands and position results.
// -----------------------------------------------------------------------------
`default_nettype none
interface drp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] speed;
   logic [31:0] timestamp;
   logic [15:0] heading;
   logic        first;
   modport source (output valid, speed, timestamp, heading, first, input ready);
   modport sink   (input valid, speed, timestamp, heading, first, output ready);
endinterface

interface drp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] pos_x;
   logic signed [63:0] pos_y;
   modport source (output valid, pos_x, pos_y, input ready);
   modport sink   (input valid, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/drp_cordic.sv @@
// -----------------------------------------------------------------------------
// drp_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, q1.15 results.
// -----------------------------------------------------------------------------
`default_nettype none
module drp_cordic #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [drp_pkg::HEAD_W-1:0]          heading,
   output      drp_pkg::cordic_ctl_type             ctl,
   output      logic signed [drp_pkg::TRIG_W-1:0]   cos_q15,
   output      logic signed [drp_pkg::TRIG_W-1:0]   sin_q15
);
   localparam int NSTEP = (CORDIC_STEPS < drp_pkg::TAB_LEN) ? CORDIC_STEPS
                                                            : drp_pkg::TAB_LEN;
   localparam int DROP = 32 - ANGLE_BITS;

   logic signed [drp_pkg::CRD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [drp_pkg::ANG_W-1:0] z_ff, z_in;
   logic [drp_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                             busy_ff, busy_in, neg_ff, neg_in;
   logic                             done_ff, done_in;
   logic [31:0]                      t_ang, t_fold;
   logic [drp_pkg::ANG_W-1:0]        atan_ext;
   logic signed [drp_pkg::CRD_W-1:0] xs, ys;
   logic signed [drp_pkg::TRIG_W-1:0] c_r, s_r;

   function automatic logic signed [drp_pkg::TRIG_W-1:0] to_q15(
      input logic signed [drp_pkg::CRD_W-1:0] v);
      logic signed [drp_pkg::CRD_W-1:0] r;
      r = (v + drp_pkg::CRD_W'(16384)) >>> 15;
      if (r > drp_pkg::CRD_W'(32767)) r = drp_pkg::CRD_W'(32767);
      if (r < -drp_pkg::CRD_W'(32767)) r = -drp_pkg::CRD_W'(32767);
      return r[drp_pkg::TRIG_W-1:0];
   endfunction

   always_comb begin
      t_ang    = {heading, 16'h0} & (32'hFFFF_FFFF << DROP);
      t_fold   = (t_ang[31] ^ t_ang[30]) ? t_ang + 32'h8000_0000 : t_ang;
      atan_ext = {1'b0, drp_pkg::atan_entry(step_ff)};
      xs       = x_ff >>> step_ff;
      ys       = y_ff >>> step_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; step_in = step_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (start) begin
         x_in    = drp_pkg::GAIN_Q30;
         y_in    = '0;
         z_in    = {t_fold[31], t_fold};
         neg_in  = t_ang[31] ^ t_ang[30];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[drp_pkg::ANG_W-1]) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_ext;
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_ext;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == drp_pkg::STEP_W'(NSTEP - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      step_ff <= step_in; neg_ff <= neg_in;
   end

   always_comb begin
      c_r = to_q15(x_ff);
      s_r = to_q15(y_ff);
      cos_q15 = neg_ff ? -c_r : c_r;
      sin_q15 = neg_ff ? -s_r : s_r;
      ctl.start = busy_ff;
      ctl.done  = done_ff;
   end
endmodule
`default_nettype wire

@@ hw/rtl/drp_serial_mac.sv @@
// -----------------------------------------------------------------------------
// drp_serial_mac
// Bit-serial multiply of distance by a q1.15 trig value, rounded add with
// saturation into a 64 bit accumulator.
// -----------------------------------------------------------------------------
`default_nettype none
module drp_serial_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [drp_pkg::DIST_W-1:0]    span,
   input  wire logic signed [drp_pkg::TRIG_W-1:0]    trig,
   input  wire logic signed [drp_pkg::POS_W-1:0]     acc,
   output      logic                                 done,
   output      logic signed [drp_pkg::POS_W-1:0]     result
);
   localparam int CNT_W = 5;

   logic signed [drp_pkg::PROD_W-1:0] prod_ff, prod_in, mcand_ff, mcand_in;
   logic [drp_pkg::TRIG_W-1:0]        mplier_ff, mplier_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic                              busy_ff, busy_in, done_ff, done_in;
   logic signed [drp_pkg::PROD_W-1:0] term;
   logic signed [drp_pkg::POS_W:0]    sum;
   logic signed [drp_pkg::POS_W-1:0]  res_ff, res_in;

   // one multiplier bit per cycle; top bit carries negative weight
   always_comb begin
      prod_in = prod_ff; mcand_in = mcand_ff; mplier_in = mplier_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0; res_in = res_ff;
      term = (prod_ff + drp_pkg::PROD_W'(64)) >>> 7;
      sum  = {acc[drp_pkg::POS_W-1], acc} + term[drp_pkg::POS_W:0];
      if (start) begin
         prod_in   = '0;
         mcand_in  = drp_pkg::PROD_W'(span);
         mplier_in = trig;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            if (cnt_ff == CNT_W'(drp_pkg::TRIG_W - 1)) prod_in = prod_ff - mcand_ff;
            else prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(drp_pkg::TRIG_W)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            prod_in = prod_ff;
            if (sum[drp_pkg::POS_W] != sum[drp_pkg::POS_W-1])
               res_in = sum[drp_pkg::POS_W] ? {1'b1, {(drp_pkg::POS_W-1){1'b0}}}
                                            : {1'b0, {(drp_pkg::POS_W-1){1'b1}}};
            else
               res_in = sum[drp_pkg::POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in; mcand_ff <= mcand_in; mplier_ff <= mplier_in;
      cnt_ff <= cnt_in; res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

@@ hw/rtl/dead_reckoning_position.sv @@
// -----------------------------------------------------------------------------
// dead_reckoning_position
// Path integrator: adds speed*dt*cos/sin(heading) to a saturating q56.8
// position per command.
// -----------------------------------------------------------------------------
// One command at a time: after a command is taken, the iterative cordic runs
// its micro-rotations, then the bit-serial x and y multiply accumulates run in
// turn, and the position is held on rsp until rsp is ready. A new command is
// taken once the previous position has been transferred out. A set first flag
// restarts the path at the origin with previous time zero.
`default_nettype none
module dead_reckoning_position #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input wire logic clock,
   input wire logic reset,
   drp_req_if.sink   req,
   drp_rsp_if.source rsp
);
   drp_pkg::state_type state_ff, state_in;
   logic signed [drp_pkg::POS_W-1:0]  acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [drp_pkg::TIME_W-1:0]        prev_ff, prev_in;
   logic signed [drp_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic signed [drp_pkg::TRIG_W-1:0] cos_q15, sin_q15;
   drp_pkg::cordic_ctl_type           cctl;
   logic signed [drp_pkg::POS_W-1:0]  mac_res;
   logic                              mac_done, mac_start, cordic_start, take;
   logic signed [drp_pkg::TIME_W:0]   dt;
   logic signed [drp_pkg::TRIG_W-1:0] trig_sel;
   logic signed [drp_pkg::POS_W-1:0]  acc_sel;

   assign take = req.valid && req.ready;

   // the cordic loads its angle in the transfer cycle
   drp_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start), .heading(req.heading),
      .ctl(cctl), .cos_q15(cos_q15), .sin_q15(sin_q15));

   drp_serial_mac u_mac (
      .clock(clock), .reset(reset), .start(mac_start), .span(dist_ff),
      .trig(trig_sel), .acc(acc_sel), .done(mac_done), .result(mac_res));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drp_pkg::ST_IDLE:   if (take) state_in = drp_pkg::ST_CORDIC;
         drp_pkg::ST_CORDIC: if (cctl.done) state_in = drp_pkg::ST_MULX;
         drp_pkg::ST_MULX:   if (mac_done) state_in = drp_pkg::ST_MULY;
         drp_pkg::ST_MULY:   if (mac_done) state_in = drp_pkg::ST_DONE;
         drp_pkg::ST_DONE:   if (rsp.ready) state_in = drp_pkg::ST_IDLE;
         default:            state_in = drp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready    = (state_ff == drp_pkg::ST_IDLE);
      rsp.valid    = (state_ff == drp_pkg::ST_DONE);
      cordic_start = (state_ff == drp_pkg::ST_IDLE) && take;
      mac_start    = ((state_ff == drp_pkg::ST_CORDIC) && cctl.done) ||
                     ((state_ff == drp_pkg::ST_MULX) && mac_done);
      trig_sel     = (state_ff == drp_pkg::ST_CORDIC) ? cos_q15 : sin_q15;
      // accumulator is read when the multiply finishes
      acc_sel      = (state_ff == drp_pkg::ST_MULX) ? acc_x_ff : acc_y_ff;
      rsp.pos_x    = acc_x_ff;
      rsp.pos_y    = acc_y_ff;
   end

   always_comb begin
      acc_x_in = acc_x_ff; acc_y_in = acc_y_ff; prev_in = prev_ff;
      dist_in = dist_ff;
      dt = '0;
      if (cordic_start) begin
         dt = $signed({1'b0, req.timestamp}) -
              $signed({1'b0, (req.first ? {drp_pkg::TIME_W{1'b0}} : prev_ff)});
         dist_in = $signed({1'b0, req.speed}) * dt;
         prev_in = req.timestamp;
         if (req.first) begin
            acc_x_in = '0;
            acc_y_in = '0;
         end
      end
      if (mac_done && state_ff == drp_pkg::ST_MULX) acc_x_in = mac_res;
      if (mac_done && state_ff == drp_pkg::ST_MULY) acc_y_in = mac_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drp_pkg::ST_IDLE;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         prev_ff  <= prev_in;
      end
      dist_ff <= dist_in;
   end
endmodule
`default_nettype wire

@@ hw/rtl/drp_checker.sv @@
// -----------------------------------------------------------------------------
// drp_checker
// Port-level checks of the position integrator, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module drp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [63:0] rsp_pos_x
);
   // never accepts while a result waits
   `ASSERT_CLK(a_no_take_busy, clock, reset, !(req_ready && rsp_valid))
   // a transfer in is followed by a busy cycle
   `ASSERT_CLK(a_busy_after, clock, reset, (req_valid && req_ready) |=> !req_ready)
   // result holds while stalled
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x)))
   // nothing valid right after reset
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)
endmodule

bind dead_reckoning_position drp_checker u_drp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_pos_x(rsp.pos_x));
`default_nettype wire
